[src/bdq_pkg.sv]
// shared types, codes and defaults for the bounded deque with sorted insert
`default_nettype none

package bdq_pkg;

  // default sizes
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // configuration register widths and apb address width
  localparam int CAP_W  = 5;
  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;

  // register indexes (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_SORTED   = 1'b1;

  // command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;
  localparam logic [1:0] CMD_COUNT = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // per-cycle operation broadcast to the cell row
  typedef logic [2:0] op_t;
  localparam op_t OP_HOLD     = 3'd0;  // keep value, sorted token walk runs here
  localparam op_t OP_SHIFT_R  = 3'd1;  // take left neighbor (push front)
  localparam op_t OP_SHIFT_L  = 3'd2;  // take right neighbor (pop front)
  localparam op_t OP_WRITE_AT = 3'd3;  // the cell at the back end takes the new value
  localparam op_t OP_LOAD_AUX = 3'd4;  // copy value into the read chain
  localparam op_t OP_AUX_LEFT = 3'd5;  // read chain moves one cell toward the front

  // control for one cell
  typedef struct packed {
    op_t  op;
    logic occupied;  // cell index below entry count
    logic at_end;    // cell index equals entry count
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/bdq_cell.sv]
// one storage cell of the deque row with its sorted-insert and read-chain stages
`default_nettype none

module bdq_cell #(
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire bdq_pkg::cell_ctl_t ctl,
  input  wire [DATA_WIDTH-1:0]   new_val,
  input  wire [DATA_WIDTH-1:0]   val_left,
  input  wire [DATA_WIDTH-1:0]   val_right,
  input  wire [DATA_WIDTH-1:0]   aux_right,
  input  wire [DATA_WIDTH-1:0]   aux_in,
  input  wire                    ins_in,
  input  wire                    tok_in,
  output logic [DATA_WIDTH-1:0]  val,
  output logic [DATA_WIDTH-1:0]  aux,
  output logic [DATA_WIDTH-1:0]  aux_pass,
  output logic                   ins_pass,
  output logic                   tok_pass
);

  logic                  ins;
  logic                  tok;
  logic                  take;
  logic [DATA_WIDTH-1:0] val_next;
  logic [DATA_WIDTH-1:0] aux_next;

  // carried value goes in here once it is at or below the stored one,
  // after that every later cell just swaps
  assign take     = ins || (val >= aux);
  assign aux_pass = take ? val : aux;
  assign ins_pass = take;
  assign tok_pass = tok && ctl.occupied;

  always_comb begin
    val_next = val;
    unique case (ctl.op)
      bdq_pkg::OP_SHIFT_R:  val_next = val_left;
      bdq_pkg::OP_SHIFT_L:  val_next = val_right;
      bdq_pkg::OP_WRITE_AT: if (ctl.at_end) val_next = new_val;
      default: begin
        if (tok && (!ctl.occupied || take)) val_next = aux;
      end
    endcase
  end

  always_comb begin
    unique case (ctl.op)
      bdq_pkg::OP_LOAD_AUX: aux_next = val;
      bdq_pkg::OP_AUX_LEFT: aux_next = aux_right;
      default:              aux_next = aux_in;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    aux <= aux_next;
    ins <= ins_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

endmodule

`default_nettype wire

[src/bounded_deque_sorted_insert_unit.sv]
// top level of the bounded deque with optional sorted insert, built on a row of cells
//
//   channel   | direction | transfer                       | signals
//   ----------+-----------+--------------------------------+--------------------------------
//   command   | in        | start high while busy low      | command, at_front, push_value
//   result    | out       | done high for one cycle        | value_out, count_out, status
//   config    | in/out    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// push at either end, front pop/peek and read count: result on the cycle after the
//   transfer, the next command may follow at once
// sorted push: result on the next cycle, then busy while a token walks the cell row
//   from the front and ripples the insert toward the back
// back pop/peek: busy while the read chain moves the last entry to cell 0; result on
//   the cycle busy falls
// synchronous rst clears count, config, done and walk state; cell and result values stay
// results cannot be held off, done is a pure one-cycle strobe
`default_nettype none

module bounded_deque_sorted_insert_unit #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire                          clk,
  input  wire                          rst,
  // command channel
  input  wire                          start,
  output logic                         busy,
  input  wire [1:0]                    command,
  input  wire                          at_front,
  input  wire [DATA_WIDTH-1:0]         push_value,
  // result channel
  output logic                         done,
  output logic [DATA_WIDTH-1:0]        value_out,
  output logic [CNT_W-1:0]             count_out,
  output logic [1:0]                   status,
  // configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [bdq_pkg::ADDR_W-1:0]    paddr,
  input  wire [bdq_pkg::PDATA_W-1:0]   pwdata,
  output logic [bdq_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int LW = (CNT_W > bdq_pkg::CAP_W) ? CNT_W : bdq_pkg::CAP_W;

  // configuration registers
  logic [bdq_pkg::CAP_W-1:0] cap;
  logic                      sorted;
  logic                      cfg_wr;

  // control registers
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             walk;           // row busy with a walk
  logic             walk_next;
  logic             walk_sort;      // 1 sorted insert walk, 0 back read walk
  logic             walk_sort_next;
  logic             walk_pop;
  logic             walk_pop_next;
  logic [CNT_W-1:0] walk_left;      // walk steps left, zero in the last step
  logic [CNT_W-1:0] walk_left_next;
  logic             done_next;

  // result registers
  logic [DATA_WIDTH-1:0] value_out_next;
  logic [CNT_W-1:0]      count_out_next;
  logic [1:0]            status_next;

  // row control
  bdq_pkg::op_t op;
  logic         sort_start;
  logic         accept;
  logic         full;
  logic [LW-1:0] cap_ext;
  logic [LW-1:0] count_ext;
  logic [LW-1:0] limit;

  // cell row wiring
  logic [DATA_WIDTH-1:0] val_q    [DEPTH];
  logic [DATA_WIDTH-1:0] aux_q    [DEPTH];
  logic [DATA_WIDTH-1:0] aux_pass [DEPTH];
  logic                  ins_pass [DEPTH];
  logic [DEPTH-1:0]      tok_pass;

  assign accept = start && !busy;
  assign busy   = walk;
  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= '0;
      sorted <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bdq_pkg::REG_CAPACITY: cap    <= pwdata[bdq_pkg::CAP_W-1:0];
        bdq_pkg::REG_SORTED:   sorted <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bdq_pkg::REG_CAPACITY: prdata = bdq_pkg::PDATA_W'(cap);
      bdq_pkg::REG_SORTED:   prdata = bdq_pkg::PDATA_W'(sorted);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // active limit: capacity register, or DEPTH when zero or above DEPTH
  // ---------------------------------------------------------------------------
  assign cap_ext   = LW'(cap);
  assign count_ext = LW'(count);
  assign limit     = ((cap == '0) || (cap_ext > LW'(DEPTH))) ? LW'(DEPTH) : cap_ext;
  assign full      = count_ext >= limit;

  // ---------------------------------------------------------------------------
  // command decode and walk sequencing
  // ---------------------------------------------------------------------------
  always_comb begin
    op             = bdq_pkg::OP_HOLD;
    sort_start     = 1'b0;
    count_next     = count;
    walk_next      = walk;
    walk_sort_next = walk_sort;
    walk_pop_next  = walk_pop;
    walk_left_next = walk_left;
    done_next      = 1'b0;
    value_out_next = value_out;
    count_out_next = count_out;
    status_next    = status;

    if (accept) begin
      value_out_next = '0;
      status_next    = bdq_pkg::ST_OK;
      count_out_next = count;
      unique case (command) inside
        bdq_pkg::CMD_PUSH: begin
          done_next = 1'b1;
          if (full) begin
            status_next = bdq_pkg::ST_FULL;
          end else if (sorted) begin
            // token enters cell 0, count grows when it reaches the end cell
            sort_start     = 1'b1;
            walk_next      = 1'b1;
            walk_sort_next = 1'b1;
            walk_left_next = count;
          end else begin
            op         = at_front ? bdq_pkg::OP_SHIFT_R : bdq_pkg::OP_WRITE_AT;
            count_next = count + CNT_W'(1);
          end
        end
        bdq_pkg::CMD_POP, bdq_pkg::CMD_PEEK: begin
          if (count == '0) begin
            done_next   = 1'b1;
            status_next = bdq_pkg::ST_EMPTY;
          end else if (at_front) begin
            done_next      = 1'b1;
            value_out_next = val_q[0];
            if (command == bdq_pkg::CMD_POP) begin
              op             = bdq_pkg::OP_SHIFT_L;
              count_next     = count - CNT_W'(1);
              count_out_next = count - CNT_W'(1);
            end
          end else begin
            // back end: load the read chain and shift it toward cell 0
            op             = bdq_pkg::OP_LOAD_AUX;
            walk_next      = 1'b1;
            walk_sort_next = 1'b0;
            walk_pop_next  = (command == bdq_pkg::CMD_POP);
            walk_left_next = count - CNT_W'(1);
          end
        end
        default: begin
          done_next = 1'b1;
        end
      endcase
    end else if (walk) begin
      if (!walk_sort) op = bdq_pkg::OP_AUX_LEFT;
      walk_left_next = walk_left - CNT_W'(1);
      if (walk_left == '0) begin
        walk_next = 1'b0;
        if (walk_sort) begin
          count_next = count + CNT_W'(1);
        end else begin
          // last entry has reached cell 0 of the read chain
          done_next      = 1'b1;
          value_out_next = aux_q[0];
          status_next    = bdq_pkg::ST_OK;
          if (walk_pop) begin
            count_next     = count - CNT_W'(1);
            count_out_next = count - CNT_W'(1);
          end else begin
            count_out_next = count;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      walk      <= 1'b0;
      walk_sort <= 1'b0;
      walk_pop  <= 1'b0;
      walk_left <= '0;
      done      <= 1'b0;
    end else begin
      count     <= count_next;
      walk      <= walk_next;
      walk_sort <= walk_sort_next;
      walk_pop  <= walk_pop_next;
      walk_left <= walk_left_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    value_out <= value_out_next;
    count_out <= count_out_next;
    status    <= status_next;
  end

  // ---------------------------------------------------------------------------
  // cell row: cell 0 is the front, cell count-1 the back
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bdq_pkg::cell_ctl_t    ctl;
    logic [DATA_WIDTH-1:0] val_left;
    logic [DATA_WIDTH-1:0] val_right;
    logic [DATA_WIDTH-1:0] aux_right;
    logic [DATA_WIDTH-1:0] aux_in;
    logic                  ins_in;
    logic                  tok_in;

    assign ctl.op       = op;
    assign ctl.occupied = CNT_W'(i) < count;
    assign ctl.at_end   = CNT_W'(i) == count;

    if (i == 0) begin : g_head
      // the front cell is fed from the command
      assign val_left = push_value;
      assign aux_in   = push_value;
      assign ins_in   = 1'b0;
      assign tok_in   = sort_start;
    end else begin : g_body
      assign val_left = val_q[i-1];
      assign aux_in   = aux_pass[i-1];
      assign ins_in   = ins_pass[i-1];
      assign tok_in   = tok_pass[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign val_right = val_q[i];
      assign aux_right = aux_q[i];
    end else begin : g_inner
      assign val_right = val_q[i+1];
      assign aux_right = aux_q[i+1];
    end

    bdq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_val   (push_value),
      .val_left  (val_left),
      .val_right (val_right),
      .aux_right (aux_right),
      .aux_in    (aux_in),
      .ins_in    (ins_in),
      .tok_in    (tok_in),
      .val       (val_q[i]),
      .aux       (aux_q[i]),
      .aux_pass  (aux_pass[i]),
      .ins_pass  (ins_pass[i]),
      .tok_pass  (tok_pass[i])
    );
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every transfer either answers on the next cycle or starts a walk
  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || walk))
    else $error("accepted command gave neither result nor walk");

  // entry count stays within the row
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_ext <= LW'(DEPTH))
    else $error("entry count above depth");

  // at most one insert token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_pass))
    else $error("more than one insert token in flight");

  // a finished sorted walk adds exactly one entry
  a_sort_grows: assert property (@(posedge clk) disable iff (rst)
    (walk && walk_sort && (walk_left == '0)) |=> (count == $past(count) + CNT_W'(1)))
    else $error("sorted insert did not add one entry");

  // a finished back read delivers its result and frees the block
  a_back_done: assert property (@(posedge clk) disable iff (rst)
    (walk && !walk_sort && (walk_left == '0)) |=> (done && !busy))
    else $error("back read finished without result");

endmodule

`default_nettype wire
